### src/lcs_pkg.sv
// Shared types and codes for the longest common subsequence block.
package lcs_pkg;

   // Command codes carried in the selector of an input item
   localparam logic [1:0] CMD_LOAD_A = 2'd0;
   localparam logic [1:0] CMD_LOAD_B = 2'd1;
   localparam logic [1:0] CMD_RUN    = 2'd2;

   // Stream payload widths
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_TUSER_W = 2;
   localparam int CHAR_W      = 8;
   localparam int LEN_OUT_W   = 6;

   // Controller to datapath commands
   typedef struct packed {
      logic              load_a;
      logic              load_b;
      logic              clear_run;
      logic              len_clr;
      logic              fill_issue;
      logic              tb_init;
      logic              tb_issue;
      logic              tb_step;
      logic              ans_rd;
      logic              first_row;
      logic              first_col;
      logic [CHAR_W-1:0] char_val;
   } lcs_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic up_eq;
      logic left_eq;
   } lcs_sts_type;

endpackage

### src/lcs_ctrl.sv
// Sequencer for load, table fill, trace back and result emission.
module lcs_ctrl #(
   parameter int MAX_LEN = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [1:0]                          req_cmd,
   input  logic [lcs_pkg::CHAR_W-1:0]          req_char,
   output logic                                rsp_tvalid,
   output logic                                rsp_tlast,
   input  logic                                rsp_tready,
   input  logic [$clog2(MAX_LEN+1)-1:0]        a_count,
   input  logic [$clog2(MAX_LEN+1)-1:0]        b_count,
   input  logic [$clog2(MAX_LEN+1)-1:0]        len,
   input  lcs_pkg::lcs_sts_type                sts,
   output lcs_pkg::lcs_cmd_type                cmd,
   output logic [$clog2(MAX_LEN+1)-1:0]        row,
   output logic [$clog2(MAX_LEN+1)-1:0]        col,
   output logic [$clog2(MAX_LEN+1)-1:0]        idx
);

   localparam int CW = $clog2(MAX_LEN + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_DRAIN,
      ST_TB_INIT,
      ST_TB_RD,
      ST_TB_EV,
      ST_EM_RD,
      ST_EM_OUT
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   i_ff, i_in;
   logic [CW-1:0]   j_ff, j_in;
   logic [CW-1:0]   k_ff, k_in;
   logic            valid_ff, valid_in;
   logic            last_ff, last_in;
   logic            tb_done;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      valid_in     = valid_ff;
      last_in      = last_ff;
      tb_done      = 1'b0;
      cmd          = '0;
      cmd.char_val = req_char;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_cmd)
                  lcs_pkg::CMD_LOAD_A: cmd.load_a = 1'b1;
                  lcs_pkg::CMD_LOAD_B: cmd.load_b = 1'b1;
                  lcs_pkg::CMD_RUN: begin
                     if (a_count == '0 || b_count == '0) begin
                        cmd.len_clr = 1'b1;
                        valid_in    = 1'b1;
                        last_in     = 1'b1;
                        state_in    = ST_EM_OUT;
                     end else begin
                        i_in     = CW'(1);
                        j_in     = CW'(1);
                        state_in = ST_FILL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FILL: begin
            cmd.fill_issue = 1'b1;
            cmd.first_row  = (i_ff == CW'(1));
            cmd.first_col  = (j_ff == CW'(1));
            if (j_ff == b_count) begin
               j_in = CW'(1);
               if (i_ff == a_count) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in = CW'(i_ff + 1'b1);
               end
            end else begin
               j_in = CW'(j_ff + 1'b1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_TB_INIT;
         end
         ST_TB_INIT: begin
            cmd.tb_init = 1'b1;
            k_in        = len;
            i_in        = a_count;
            j_in        = b_count;
            if (len == '0) begin
               valid_in = 1'b1;
               last_in  = 1'b1;
               state_in = ST_EM_OUT;
            end else begin
               state_in = ST_TB_RD;
            end
         end
         ST_TB_RD: begin
            cmd.tb_issue  = 1'b1;
            cmd.first_row = (i_ff == CW'(1));
            cmd.first_col = (j_ff == CW'(1));
            state_in      = ST_TB_EV;
         end
         ST_TB_EV: begin
            cmd.tb_step = 1'b1;
            if (sts.up_eq) begin
               i_in    = CW'(i_ff - 1'b1);
               tb_done = (i_ff == CW'(1));
            end else if (sts.left_eq) begin
               j_in    = CW'(j_ff - 1'b1);
               tb_done = (j_ff == CW'(1));
            end else begin
               i_in    = CW'(i_ff - 1'b1);
               j_in    = CW'(j_ff - 1'b1);
               k_in    = CW'(k_ff - 1'b1);
               tb_done = (i_ff == CW'(1)) || (j_ff == CW'(1));
            end
            if (tb_done) begin
               k_in     = '0;
               state_in = ST_EM_RD;
            end else begin
               state_in = ST_TB_RD;
            end
         end
         ST_EM_RD: begin
            cmd.ans_rd = 1'b1;
            valid_in   = 1'b1;
            last_in    = (CW'(k_ff + 1'b1) == len);
            state_in   = ST_EM_OUT;
         end
         ST_EM_OUT: begin
            if (rsp_tready) begin
               valid_in = 1'b0;
               if (last_ff) begin
                  cmd.clear_run = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  k_in     = CW'(k_ff + 1'b1);
                  state_in = ST_EM_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign row        = i_ff;
   assign col        = j_ff;
   assign idx        = k_ff;

endmodule

### src/lcs_dpath.sv
// String stores, length table, answer buffer and cell arithmetic.
module lcs_dpath #(
   parameter int MAX_LEN = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lcs_pkg::lcs_cmd_type                cmd,
   input  logic [$clog2(MAX_LEN+1)-1:0]        row,
   input  logic [$clog2(MAX_LEN+1)-1:0]        col,
   input  logic [$clog2(MAX_LEN+1)-1:0]        idx,
   output lcs_pkg::lcs_sts_type                sts,
   output logic [$clog2(MAX_LEN+1)-1:0]        a_count,
   output logic [$clog2(MAX_LEN+1)-1:0]        b_count,
   output logic [$clog2(MAX_LEN+1)-1:0]        len,
   output logic [lcs_pkg::CHAR_W-1:0]          char_out,
   output logic [lcs_pkg::LEN_OUT_W-1:0]       lcs_length,
   output logic                                is_empty,
   output logic                                overflow
);

   localparam int CW    = $clog2(MAX_LEN + 1);
   localparam int IW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int DIM   = MAX_LEN + 1;
   localparam int DEPTH = DIM * DIM;
   localparam int AW    = $clog2(DEPTH);

   logic [lcs_pkg::CHAR_W-1:0] a_mem   [MAX_LEN];
   logic [lcs_pkg::CHAR_W-1:0] b_mem   [MAX_LEN];
   logic [lcs_pkg::CHAR_W-1:0] ans_mem [MAX_LEN];
   logic [CW-1:0]              tbl_mem [DEPTH];

   logic [lcs_pkg::CHAR_W-1:0] a_rd_ff, b_rd_ff, ans_rd_ff;
   logic [CW-1:0]              tbl_rd0_ff, tbl_rd1_ff;
   logic                       s1_valid_ff;
   logic [AW-1:0]              s1_addr_ff;
   logic                       first_row_ff, first_col_ff;
   logic                       byp_ff, byp_in;
   logic [CW-1:0]              byp_val_ff;
   logic [CW-1:0]              left_ff, diag_ff, len_ff, here_ff;
   logic [CW-1:0]              a_count_ff, b_count_ff;
   logic                       dropped_ff;

   logic [CW-1:0]              row_m1, col_m1, idx_m1;
   logic [AW-1:0]              addr_up, addr_left, addr_here;
   logic [CW-1:0]              up_v, left_v, diag_v, left_tb, cell_v;
   logic                       match, rd_en, diag_take;

   assign row_m1    = CW'(row - 1'b1);
   assign col_m1    = CW'(col - 1'b1);
   assign idx_m1    = CW'(idx - 1'b1);
   assign addr_up   = AW'(AW'(row_m1) * AW'(DIM) + AW'(col));
   assign addr_left = AW'(AW'(row) * AW'(DIM) + AW'(col_m1));
   assign addr_here = AW'(AW'(row) * AW'(DIM) + AW'(col));
   assign rd_en     = cmd.fill_issue || cmd.tb_issue;

   // Cell (i, j) from the cell above, to the left and on the diagonal
   assign up_v   = first_row_ff ? '0 : (byp_ff ? byp_val_ff : tbl_rd0_ff);
   assign left_v = first_col_ff ? '0 : left_ff;
   assign diag_v = first_col_ff ? '0 : diag_ff;
   assign match  = (a_rd_ff == b_rd_ff);
   assign cell_v = match ? CW'(diag_v + 1'b1) : ((left_v > up_v) ? left_v : up_v);

   // Trace back compares
   assign left_tb     = first_col_ff ? '0 : tbl_rd1_ff;
   assign sts.up_eq   = (here_ff == up_v);
   assign sts.left_eq = (here_ff == left_tb);
   assign diag_take   = cmd.tb_step && !sts.up_eq && !sts.left_eq && (idx != '0);

   // Forward a cell written in the same cycle as it is read back
   assign byp_in = cmd.fill_issue && s1_valid_ff && (s1_addr_ff == addr_up);

   always_ff @(posedge clock) begin
      if (cmd.load_a && a_count_ff < CW'(MAX_LEN)) begin
         a_mem[a_count_ff[IW-1:0]] <= cmd.char_val;
      end
      if (cmd.load_b && b_count_ff < CW'(MAX_LEN)) begin
         b_mem[b_count_ff[IW-1:0]] <= cmd.char_val;
      end
      if (rd_en) begin
         a_rd_ff <= a_mem[row_m1[IW-1:0]];
         b_rd_ff <= b_mem[col_m1[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         tbl_mem[s1_addr_ff] <= cell_v;
      end
      if (rd_en) begin
         tbl_rd0_ff <= tbl_mem[addr_up];
      end
      if (cmd.tb_issue) begin
         tbl_rd1_ff <= tbl_mem[addr_left];
      end
   end

   always_ff @(posedge clock) begin
      if (diag_take) begin
         ans_mem[idx_m1[IW-1:0]] <= a_rd_ff;
      end
      if (cmd.ans_rd) begin
         ans_rd_ff <= ans_mem[idx[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         a_count_ff  <= '0;
         b_count_ff  <= '0;
         dropped_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.fill_issue;
         if (cmd.clear_run) begin
            a_count_ff <= '0;
            b_count_ff <= '0;
            dropped_ff <= 1'b0;
         end else begin
            if (cmd.load_a) begin
               if (a_count_ff < CW'(MAX_LEN)) begin
                  a_count_ff <= CW'(a_count_ff + 1'b1);
               end else begin
                  dropped_ff <= 1'b1;
               end
            end
            if (cmd.load_b) begin
               if (b_count_ff < CW'(MAX_LEN)) begin
                  b_count_ff <= CW'(b_count_ff + 1'b1);
               end else begin
                  dropped_ff <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff   <= addr_here;
      first_row_ff <= cmd.first_row;
      first_col_ff <= cmd.first_col;
      byp_ff       <= byp_in;
      byp_val_ff   <= cell_v;
      if (s1_valid_ff) begin
         left_ff <= cell_v;
         diag_ff <= up_v;
      end
      if (cmd.len_clr) begin
         len_ff <= '0;
      end else if (s1_valid_ff) begin
         len_ff <= cell_v;
      end
      if (cmd.tb_init) begin
         here_ff <= len_ff;
      end else if (cmd.tb_step) begin
         if (sts.up_eq) begin
            here_ff <= up_v;
         end else if (sts.left_eq) begin
            here_ff <= left_tb;
         end else begin
            here_ff <= CW'(here_ff - 1'b1);
         end
      end
   end

   assign a_count    = a_count_ff;
   assign b_count    = b_count_ff;
   assign len        = len_ff;
   assign is_empty   = (len_ff == '0);
   assign char_out   = is_empty ? '0 : ans_rd_ff;
   assign lcs_length = lcs_pkg::LEN_OUT_W'(len_ff);
   assign overflow   = dropped_ff;

endmodule

### src/lcs_dynamic_programming.sv
// Top level of the longest common subsequence block.
//
// Load items (selector 0 for string A, 1 for string B) append one byte each and are taken
// one per cycle; bytes beyond MAX_LEN per string are dropped and raise a sticky overflow
// flag. A run item (selector 2) fills the (m+1) by (n+1) length table one cell a cycle
// through the table memory's read and write ports, then traces back from the corner in
// steps of a registered read of the cells above and to the left followed by a decision,
// at most m + n steps. On a tie the trace moves up first, then left, and otherwise
// takes the diagonal and keeps the byte. The subsequence is then emitted left to right,
// each result read from the answer buffer and then held until rsp_tready, with the
// final result marked by rsp_tlast; an empty subsequence gives a single result flagged
// empty with zero data. Each result carries the total length (low six bits) and the
// overflow flag. Once the last result of a run is taken both strings and the overflow
// flag are cleared. No item is accepted during a run. Selector 3 is taken and ignored.
// No clearing pass runs after reset.
module lcs_dynamic_programming #(
   parameter int MAX_LEN = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // input item
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lcs_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [7:0] char_in
   input  logic [lcs_pkg::REQ_TUSER_W-1:0]    req_tuser,  // [1:0] cmd
   // result item
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lcs_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // [7:0] char_out, [13:8] lcs_length
   output logic [lcs_pkg::RSP_TUSER_W-1:0]    rsp_tuser,  // [0] is_empty, [1] overflow
   output logic                               rsp_tlast   // last
);

   localparam int CW = $clog2(MAX_LEN + 1);

   lcs_pkg::lcs_cmd_type            cmd;
   lcs_pkg::lcs_sts_type            sts;
   logic [CW-1:0]                   a_count, b_count, len;
   logic [CW-1:0]                   row, col, idx;
   logic [lcs_pkg::CHAR_W-1:0]      char_out;
   logic [lcs_pkg::LEN_OUT_W-1:0]   lcs_length;
   logic                            is_empty, overflow;

   // Sequence load, fill, trace back and emission
   lcs_ctrl #(
      .MAX_LEN (MAX_LEN)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser[1:0]),
      .req_char   (req_tdata[7:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tlast  (rsp_tlast),
      .rsp_tready (rsp_tready),
      .a_count    (a_count),
      .b_count    (b_count),
      .len        (len),
      .sts        (sts),
      .cmd        (cmd),
      .row        (row),
      .col        (col),
      .idx        (idx)
   );

   // Hold strings, table and answer; compute cells and trace back decisions
   lcs_dpath #(
      .MAX_LEN (MAX_LEN)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .row        (row),
      .col        (col),
      .idx        (idx),
      .sts        (sts),
      .a_count    (a_count),
      .b_count    (b_count),
      .len        (len),
      .char_out   (char_out),
      .lcs_length (lcs_length),
      .is_empty   (is_empty),
      .overflow   (overflow)
   );

   // Pack the result item
   assign rsp_tdata = {2'b00, lcs_length, char_out};
   assign rsp_tuser = {overflow, is_empty};

endmodule

### src/lcs_checker.sv
// Port-level checks for the longest common subsequence block, bound to the top level.
module lcs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [lcs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input logic [lcs_pkg::REQ_TUSER_W-1:0]    req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [lcs_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input logic [lcs_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   input logic                               rsp_tlast
);

   // Come out of reset idle and ready
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Take no item while a result is offered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input ready while a result is pending");

   // Empty result is a lone, zeroed, final item
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && rsp_tdata[13:0] == 14'd0)
      else $error("malformed empty result");

   // Return to idle once the final item is taken
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("block not idle after final result");

endmodule

bind lcs_dynamic_programming lcs_checker u_checker (.*);
